@@ rtl/core/rvl_pkg.sv @@
// ----------------------------------------------------------------------------
// rvl_pkg
// shared types, register indexes and reset values of the vehicle lamp block
// ----------------------------------------------------------------------------
package rvl_pkg;

    localparam int WIDTH_W   = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_STEER_CENTRE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_DEAD_ZONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_CENTRE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_DEAD_ZONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_INTERVAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_HOLD      = 3'd5;

    localparam logic [WIDTH_W-1:0] RST_STEER_CENTRE    = 16'd1505;
    localparam logic [WIDTH_W-1:0] RST_STEER_DEAD_ZONE = 16'd30;
    localparam logic [WIDTH_W-1:0] RST_THR_CENTRE      = 16'd1493;
    localparam logic [WIDTH_W-1:0] RST_THR_DEAD_ZONE   = 16'd8;
    localparam logic [WIDTH_W-1:0] RST_BLINK_INTERVAL  = 16'd500;
    localparam logic [WIDTH_W-1:0] RST_BRAKE_HOLD      = 16'd250;

    typedef enum logic [1:0] {
        CLS_CENTRE = 2'd0,
        CLS_LEFT   = 2'd1,
        CLS_RIGHT  = 2'd2
    } cls_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] steer_centre;
        logic [WIDTH_W-1:0] steer_dead_zone;
        logic [WIDTH_W-1:0] throttle_centre;
        logic [WIDTH_W-1:0] throttle_dead_zone;
        logic [WIDTH_W-1:0] blink_interval_ms;
        logic [WIDTH_W-1:0] brake_hold_ms;
    } cfg_t;

    typedef struct packed {
        cls_t              cls;
        logic              rev;
        logic              thr_drop;
        logic              thr_rise;
        logic              above_fwd;
        logic [TIME_W-1:0] now_ms;
    } item_t;

endpackage

@@ rtl/core/rc_vehicle_light_controller.sv @@
// ----------------------------------------------------------------------------
// rc_vehicle_light_controller
// turn, brake and reverse lamp control from steering and throttle samples
// ----------------------------------------------------------------------------
// Accepts one sample per clock while the queue has room and returns one lamp
// result per sample, in order. A sample is classified on the cycle it is
// taken in, waits in a two-entry queue, and its lamp result is then written
// into the output register, which raises out_valid; while the output side
// stalls, samples wait in the queue. The queue and the output register keep
// the rate at one sample per cycle while the output side takes results.
// Configuration writes are accepted on every cycle and must only be issued
// while no sample is in flight.
module rc_vehicle_light_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rvl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rvl_pkg::WIDTH_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rvl_pkg::WIDTH_W-1:0]    steer_width,
    input  logic [rvl_pkg::WIDTH_W-1:0]    throttle_width,
    input  logic [rvl_pkg::TIME_W-1:0]     now_ms,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           left_lamp,
    output logic                           right_lamp,
    output logic                           brake_lamp,
    output logic                           reverse_lamp
);
    import rvl_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_STEER_CENTRE:    cfg_next.steer_centre       = cfg_data;
                REG_STEER_DEAD_ZONE: cfg_next.steer_dead_zone    = cfg_data;
                REG_THR_CENTRE:      cfg_next.throttle_centre    = cfg_data;
                REG_THR_DEAD_ZONE:   cfg_next.throttle_dead_zone = cfg_data;
                REG_BLINK_INTERVAL:  cfg_next.blink_interval_ms  = cfg_data;
                REG_BRAKE_HOLD:      cfg_next.brake_hold_ms      = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steer_centre       <= RST_STEER_CENTRE;
            cfg_reg.steer_dead_zone    <= RST_STEER_DEAD_ZONE;
            cfg_reg.throttle_centre    <= RST_THR_CENTRE;
            cfg_reg.throttle_dead_zone <= RST_THR_DEAD_ZONE;
            cfg_reg.blink_interval_ms  <= RST_BLINK_INTERVAL;
            cfg_reg.brake_hold_ms      <= RST_BRAKE_HOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rvl_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .steer_width    (steer_width),
        .throttle_width (throttle_width),
        .now_ms         (now_ms),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    rvl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    rvl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_lamp    (left_lamp),
        .right_lamp   (right_lamp),
        .brake_lamp   (brake_lamp),
        .reverse_lamp (reverse_lamp)
    );

endmodule

@@ rtl/core/rvl_front.sv @@
// ----------------------------------------------------------------------------
// rvl_front
// classifies each sample and tracks the previous throttle width
// ----------------------------------------------------------------------------
module rvl_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rvl_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rvl_pkg::WIDTH_W-1:0]  steer_width,
    input  logic [rvl_pkg::WIDTH_W-1:0]  throttle_width,
    input  logic [rvl_pkg::TIME_W-1:0]   now_ms,
    output logic                         push_valid,
    input  logic                         push_ready,
    output rvl_pkg::item_t               push_item
);
    import rvl_pkg::*;

    logic [WIDTH_W-1:0] prev_thr_reg;
    logic [WIDTH_W-1:0] prev_thr_next;
    logic [WIDTH_W-1:0] s_eff;
    logic [WIDTH_W-1:0] c_eff;
    logic [WIDTH_W:0]   s_hi;
    logic [WIDTH_W:0]   s_plus;
    logic [WIDTH_W:0]   t_hi;
    logic [WIDTH_W:0]   c_plus;
    logic [WIDTH_W:0]   p_plus;
    logic               push;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push       = in_valid && push_ready;

    always_comb
    begin
        s_eff  = (steer_width == '0) ? cfg.steer_centre : steer_width;
        c_eff  = (throttle_width == '0) ? cfg.throttle_centre : throttle_width;
        s_hi   = {1'b0, cfg.steer_centre} + {1'b0, cfg.steer_dead_zone};
        s_plus = {1'b0, s_eff} + {1'b0, cfg.steer_dead_zone};
        t_hi   = {1'b0, cfg.throttle_centre} + {1'b0, cfg.throttle_dead_zone};
        c_plus = {1'b0, c_eff} + {1'b0, cfg.throttle_dead_zone};
        p_plus = {1'b0, prev_thr_reg} + {1'b0, cfg.throttle_dead_zone};

        if ({1'b0, s_eff} > s_hi)
        begin
            push_item.cls = CLS_RIGHT;
        end
        else if (s_plus < {1'b0, cfg.steer_centre})
        begin
            push_item.cls = CLS_LEFT;
        end
        else
        begin
            push_item.cls = CLS_CENTRE;
        end

        push_item.rev       = (c_plus < {1'b0, cfg.throttle_centre});
        push_item.thr_drop  = (c_plus < {1'b0, prev_thr_reg});
        push_item.thr_rise  = ({1'b0, c_eff} > p_plus);
        push_item.above_fwd = ({1'b0, c_eff} > t_hi);
        push_item.now_ms    = now_ms;

        prev_thr_next = push ? c_eff : prev_thr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_thr_reg <= RST_THR_CENTRE;
        end
        else
        begin
            prev_thr_reg <= prev_thr_next;
        end
    end

endmodule

@@ rtl/core/rvl_queue.sv @@
// ----------------------------------------------------------------------------
// rvl_queue
// two-entry queue between classification and lamp update
// ----------------------------------------------------------------------------
module rvl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rvl_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rvl_pkg::item_t pop_item
);
    import rvl_pkg::*;

    item_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == Q_CNT_W'(Q_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

@@ rtl/core/rvl_back.sv @@
// ----------------------------------------------------------------------------
// rvl_back
// turn signal blinking, brake hold and the lamp output register
// ----------------------------------------------------------------------------
module rvl_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rvl_pkg::cfg_t        cfg,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  rvl_pkg::item_t       pop_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 left_lamp,
    output logic                 right_lamp,
    output logic                 brake_lamp,
    output logic                 reverse_lamp
);
    import rvl_pkg::*;

    cls_t              prev_cls_reg;
    cls_t              prev_cls_next;
    logic              lphase_reg;
    logic              lphase_next;
    logic              rphase_reg;
    logic              rphase_next;
    logic [TIME_W-1:0] blink_start_reg;
    logic [TIME_W-1:0] blink_start_next;
    logic              brake_active_reg;
    logic              brake_active_next;
    logic              brake_started_reg;
    logic              brake_started_next;
    logic [TIME_W-1:0] brake_start_reg;
    logic [TIME_W-1:0] brake_start_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              left_reg;
    logic              right_reg;
    logic              brake_reg;
    logic              rev_reg;
    logic              left_next;
    logic              right_next;
    logic              brake_next;
    logic [TIME_W-1:0] blink_age;
    logic [TIME_W-1:0] brake_age;
    logic              pop;

    assign pop_ready    = !out_valid_reg || out_ready;
    assign pop          = pop_valid && pop_ready;
    assign out_valid    = out_valid_reg;
    assign left_lamp    = left_reg;
    assign right_lamp   = right_reg;
    assign brake_lamp   = brake_reg;
    assign reverse_lamp = rev_reg;

    // blink state
    always_comb
    begin
        prev_cls_next    = prev_cls_reg;
        lphase_next      = lphase_reg;
        rphase_next      = rphase_reg;
        blink_start_next = blink_start_reg;
        blink_age        = pop_item.now_ms - blink_start_reg;
        if (pop)
        begin
            if (pop_item.cls == CLS_CENTRE)
            begin
                prev_cls_next = CLS_CENTRE;
            end
            else if (prev_cls_reg != pop_item.cls)
            begin
                if (pop_item.cls == CLS_LEFT)
                begin
                    lphase_next = 1'b1;
                end
                else
                begin
                    rphase_next = 1'b1;
                end
                blink_start_next = pop_item.now_ms;
                prev_cls_next    = pop_item.cls;
            end
            else if (blink_age > {{(TIME_W-WIDTH_W){1'b0}}, cfg.blink_interval_ms})
            begin
                if (pop_item.cls == CLS_LEFT)
                begin
                    lphase_next = !lphase_reg;
                end
                else
                begin
                    rphase_next = !rphase_reg;
                end
                blink_start_next = pop_item.now_ms;
            end
        end
        left_next  = (pop_item.cls == CLS_LEFT) && lphase_next;
        right_next = (pop_item.cls == CLS_RIGHT) && rphase_next;
    end

    // brake state
    always_comb
    begin
        brake_active_next  = brake_active_reg;
        brake_started_next = brake_started_reg;
        brake_start_next   = brake_start_reg;
        if (pop)
        begin
            if (pop_item.thr_drop)
            begin
                if (pop_item.above_fwd)
                begin
                    brake_active_next  = 1'b1;
                    brake_started_next = 1'b1;
                    brake_start_next   = pop_item.now_ms;
                end
                else
                begin
                    brake_active_next = 1'b0;
                end
            end
            else if (pop_item.thr_rise)
            begin
                if (pop_item.rev)
                begin
                    brake_active_next  = 1'b1;
                    brake_started_next = 1'b1;
                    brake_start_next   = pop_item.now_ms;
                end
            end
            else
            begin
                brake_active_next = 1'b0;
            end
        end
        brake_age  = pop_item.now_ms - brake_start_next;
        brake_next = brake_active_next || (brake_started_next &&
                     (brake_age < {{(TIME_W-WIDTH_W){1'b0}}, cfg.brake_hold_ms}));
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cls_reg      <= CLS_CENTRE;
            lphase_reg        <= 1'b0;
            rphase_reg        <= 1'b0;
            blink_start_reg   <= '0;
            brake_active_reg  <= 1'b0;
            brake_started_reg <= 1'b0;
            brake_start_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            prev_cls_reg      <= prev_cls_next;
            lphase_reg        <= lphase_next;
            rphase_reg        <= rphase_next;
            blink_start_reg   <= blink_start_next;
            brake_active_reg  <= brake_active_next;
            brake_started_reg <= brake_started_next;
            brake_start_reg   <= brake_start_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            brake_reg <= brake_next;
            rev_reg   <= pop_item.rev;
        end
    end

    a_one_turn_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(left_reg && right_reg))
        else $error("both turn lamps lit");

    a_active_started: assert property (@(posedge clk) disable iff (!rst_n)
        brake_active_reg |-> brake_started_reg)
        else $error("brake active without a brake event");

endmodule
